/* hw/rtl/hpack_pkg.sv */
// Shared types, canonical code tables and FSM states for the HPACK Huffman decoder.
// No dependencies; the tables are built at elaboration from the code lengths.
package hpack_pkg;

    localparam int NumSym   = 257;
    localparam int MaxLen   = 30;
    localparam int EosIndex = 256;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SYM = 2'd0;
    localparam t_kind KIND_OK  = 2'd1;
    localparam t_kind KIND_ERR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic       hit;   // complete non-EOS code
        logic       bad;   // EOS code or no code within the longest length
        logic [7:0] sym;
    } t_match;

    typedef logic [4:0]  t_len_tab  [NumSym];
    typedef logic [8:0]  t_cnt_arr  [32];
    typedef logic [29:0] t_code_arr [32];
    typedef logic [7:0]  t_sym_arr  [256];

    localparam t_len_tab CODE_LEN = '{
        13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
        28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
        6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
        5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
        13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
        7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
        15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
        6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
        20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
        24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
        22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
        21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
        26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
        19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
        20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
        26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
        30
    };

    function automatic t_cnt_arr f_count();
        t_cnt_arr a;
        for (int l = 0; l < 32; l++) a[l] = '0;
        for (int s = 0; s < NumSym; s++) a[CODE_LEN[s]] = a[CODE_LEN[s]] + 9'd1;
        return a;
    endfunction

    localparam t_cnt_arr LEN_COUNT = f_count();

    // First canonical code of each length.
    function automatic t_code_arr f_first();
        t_code_arr   a;
        logic [30:0] c;
        for (int l = 0; l < 32; l++) a[l] = '0;
        c = '0;
        for (int l = 1; l <= MaxLen; l++) begin
            a[l] = c[29:0];
            c    = c + {22'd0, LEN_COUNT[l]};
            c    = c << 1;
        end
        return a;
    endfunction

    localparam t_code_arr LEN_FIRST = f_first();

    // Position of the first symbol of each length in the sorted list.
    function automatic t_cnt_arr f_base();
        t_cnt_arr   a;
        logic [8:0] b;
        for (int l = 0; l < 32; l++) a[l] = '0;
        b = '0;
        for (int l = 1; l <= MaxLen; l++) begin
            a[l] = b;
            b    = b + LEN_COUNT[l];
        end
        return a;
    endfunction

    localparam t_cnt_arr LEN_BASE = f_base();

    // Octets sorted by code length, then value; EOS sorts last, past the list.
    function automatic t_sym_arr f_sorted();
        t_sym_arr a;
        int       k;
        for (int i = 0; i < 256; i++) a[i] = '0;
        k = 0;
        for (int l = 1; l <= MaxLen; l++) begin
            for (int s = 0; s < 256; s++) begin
                if (int'(CODE_LEN[s]) == l) begin
                    a[k[7:0]] = s[7:0];
                    k++;
                end
            end
        end
        return a;
    endfunction

    localparam t_sym_arr SORTED_SYM = f_sorted();

endpackage

/* hw/rtl/hpack_code_match.sv */
// Canonical code match: checks whether a pending code of a given length is complete, EOS or overlong.
// Depends on hpack_pkg tables.
module hpack_code_match (
    input  logic [29:0]         i_code,
    input  logic [4:0]          i_len,
    output hpack_pkg::t_match   o_match
);
    import hpack_pkg::*;

    logic [30:0] w_diff;
    logic        w_in_range;
    logic [8:0]  w_idx;

    always_comb begin
        w_diff     = {1'b0, i_code} - {1'b0, LEN_FIRST[i_len]};
        w_in_range = !w_diff[30] && (w_diff[29:0] < {21'd0, LEN_COUNT[i_len]});
        w_idx      = LEN_BASE[i_len] + w_diff[8:0];
        o_match.hit = w_in_range && (w_idx != 9'(EosIndex));
        o_match.bad = (w_in_range && (w_idx == 9'(EosIndex)))
                   || (!w_in_range && (i_len >= 5'(MaxLen)));
        o_match.sym = SORTED_SYM[w_idx[7:0]];
    end

endmodule

/* hw/rtl/hpack_huffman_decoder_core.sv */
// HPACK (RFC 7541) Huffman string decoder, bit-serial over one coded byte.
// Flow: a byte is taken in ST_IDLE, walked one bit per cycle in ST_BIT unless stalled,
// ending early on a bad code, then wrapped up in ST_FIN, which emits a held symbol and
// then the end item when both leave. The next byte waits for ST_IDLE. A byte after an error skips the walk.
// Output back-pressure stalls the walk only when a result must leave and the slot is full.
// Reset (synchronous, active low) clears pending code, error flag and all valids.
// Depends on hpack_pkg and hpack_code_match.
module hpack_huffman_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] coded_byte
    input  logic        s_axis_tlast,   // string_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // run_last
);
    import hpack_pkg::*;

    t_state      r_state, n_state;
    logic [7:0]  r_sr, n_sr;          // coded byte, MSB shifted out first
    logic        r_last, n_last;
    logic [2:0]  r_bitn, n_bitn;
    logic [29:0] r_code, n_code;      // pending code, newest bit low
    logic [4:0]  r_len, n_len;
    logic        r_err, n_err;        // sticky error for this string
    logic        r_hold_valid, n_hold_valid;  // newest symbol, run_last still unknown
    logic [7:0]  r_hold_sym, n_hold_sym;
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind, n_out_kind;
    logic [7:0]  r_out_sym, n_out_sym;
    logic        r_out_last, n_out_last;

    logic [29:0] w_code;
    logic [4:0]  w_len;
    t_match      w_match;
    logic        w_out_free;
    logic        w_stall;
    logic        w_pad_ok;

    assign w_code     = {r_code[28:0], r_sr[7]};
    assign w_len      = r_len + 5'd1;
    assign w_out_free = !r_out_valid || m_axis_tready;
    // A new symbol pushes the held one out, which needs a free output slot.
    assign w_stall    = w_match.hit && r_hold_valid && !w_out_free;
    // Padding: at most 7 bits, all ones.
    assign w_pad_ok   = (r_len <= 5'd7) && (r_code[6:0] == (7'h7f >> (3'd7 - r_len[2:0])))
                     && (r_code[29:7] == '0);

    hpack_code_match u_match (
        .i_code  (w_code),
        .i_len   (w_len),
        .o_match (w_match)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = r_err ? ST_FIN : ST_BIT;
            end
            ST_BIT: begin
                if (!w_stall && (w_match.bad || r_bitn == 3'd7)) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (r_hold_valid) begin
                    if (w_out_free && !r_last) n_state = ST_IDLE;
                end else if (!r_last || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_sr         = r_sr;
        n_last       = r_last;
        n_bitn       = r_bitn;
        n_code       = r_code;
        n_len        = r_len;
        n_err        = r_err;
        n_hold_valid = r_hold_valid;
        n_hold_sym   = r_hold_sym;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_sym    = r_out_sym;
        n_out_last   = r_out_last;
        s_axis_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sr   = s_axis_tdata;
                    n_last = s_axis_tlast;
                    n_bitn = '0;
                end
            end
            ST_BIT: begin
                if (!w_stall) begin
                    n_sr   = {r_sr[6:0], 1'b0};
                    n_bitn = r_bitn + 3'd1;
                    if (w_match.bad) begin
                        n_err  = 1'b1;
                        n_code = '0;
                        n_len  = '0;
                    end else if (w_match.hit) begin
                        n_code       = '0;
                        n_len        = '0;
                        n_hold_valid = 1'b1;
                        n_hold_sym   = w_match.sym;
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_SYM;
                            n_out_sym   = r_hold_sym;
                            n_out_last  = 1'b0;
                        end
                    end else begin
                        n_code = w_code;
                        n_len  = w_len;
                    end
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    if (r_hold_valid) begin
                        n_hold_valid = 1'b0;
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_SYM;
                        n_out_sym    = r_hold_sym;
                        n_out_last   = !r_last;
                    end else if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = (r_err || !w_pad_ok) ? KIND_ERR : KIND_OK;
                        n_out_sym   = '0;
                        n_out_last  = 1'b1;
                        n_code      = '0;
                        n_len       = '0;
                        n_err       = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_code       <= '0;
            r_len        <= '0;
            r_err        <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_code       <= n_code;
            r_len        <= n_len;
            r_err        <= n_err;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr       <= n_sr;
        r_last     <= n_last;
        r_bitn     <= n_bitn;
        r_hold_sym <= n_hold_sym;
        r_out_kind <= n_out_kind;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 5'(MaxLen))
        else $error("pending code length out of range");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("held symbol left behind at byte end");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_SYM) |-> r_out_last)
        else $error("end item without run_last");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_last && !r_hold_valid && w_out_free)
        |=> (r_len == '0 && !r_err))
        else $error("string end did not clear state");
`endif

endmodule
